FILE: rtl/kmd_pkg.sv
// Shared types and constants of the key matrix debounce block.
package kmd_pkg;

    localparam int ROWS        = 4;
    localparam int COLS        = 5;
    localparam int NKEYS       = ROWS * COLS;
    localparam int ROW_W       = 2;
    localparam int COL_W       = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int KEY_W       = 5;
    localparam int TIME_W      = 32;
    localparam int DEB_W       = 16;
    localparam int EN_W        = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(100);
    localparam logic [EN_W-1:0]  ENABLE_RST   = EN_W'(1047518);

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = CFG_IDX_W'(1);

    localparam logic EV_PRESS   = 1'b0;
    localparam logic EV_RELEASE = 1'b1;

    // Events found in one row sample, one bit per column.
    typedef struct packed {
        logic [COLS-1:0]  ev;
        logic [COLS-1:0]  kind;
        logic [KEY_W-1:0] base;
    } t_row_ev;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: rtl/kmd_front.sv
// Front end: key state, debounce and ghost checks for each row sample.
module kmd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [kmd_pkg::ROW_W-1:0]     i_scan_row,
    input  logic [kmd_pkg::COLS-1:0]      i_col_pressed,
    input  logic [kmd_pkg::TIME_W-1:0]    i_time_ms,
    input  logic                          i_cfg_we,
    input  logic [kmd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  kmd_pkg::t_q_status            i_q_status,
    output logic                          o_push,
    output kmd_pkg::t_row_ev              o_row_ev
);
    import kmd_pkg::*;

    logic [DEB_W-1:0]  r_debounce;
    logic [EN_W-1:0]   r_enable;
    logic [COLS-1:0]   r_down [ROWS];
    logic [TIME_W-1:0] r_last [ROWS][COLS];

    logic              accept;
    logic              row_ok;
    logic [KEY_W-1:0]  base;
    logic [COLS-1:0]   en;
    logic [COLS-1:0]   ev;
    logic [COLS-1:0]   kind;
    logic [COLS-1:0]   n_down_row;
    logic [TIME_W-1:0] n_last_row [COLS];
    logic [COLS-1:0]   cur_down;
    logic [KEY_W-1:0]  idx;
    logic [TIME_W-1:0] elapsed;
    logic [COLS-1:0]   bit_c;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign row_ok  = ({1'b0, i_scan_row} < (ROW_W + 1)'(ROWS));
    assign base    = KEY_W'(i_scan_row) * KEY_W'(COLS);
    assign cur_down = r_down[i_scan_row];

    always_comb begin
        en         = '0;
        ev         = '0;
        kind       = '0;
        idx        = '0;
        elapsed    = '0;
        bit_c      = '0;
        n_down_row = cur_down;
        for (int c = 0; c < COLS; c++) begin
            n_last_row[c] = r_last[i_scan_row][c];
        end
        for (int c = 0; c < COLS; c++) begin
            idx     = base + KEY_W'(c);
            en[c]   = ({1'b0, idx} < (KEY_W + 1)'(EN_W)) ? r_enable[idx] : 1'b0;
            bit_c   = COLS'(1) << c;
            elapsed = i_time_ms - r_last[i_scan_row][c];
            if (en[c] && i_col_pressed[c]) begin
                // ghost rejection: only a lone pressed column may register
                if (!cur_down[c] && (elapsed > TIME_W'(r_debounce))
                    && ((i_col_pressed & ~bit_c) == '0)) begin
                    ev[c]         = 1'b1;
                    kind[c]       = EV_PRESS;
                    n_down_row[c] = 1'b1;
                    n_last_row[c] = i_time_ms;
                end
            end else if (en[c] && cur_down[c]) begin
                ev[c]         = 1'b1;
                kind[c]       = EV_RELEASE;
                n_down_row[c] = 1'b0;
            end
        end
    end

    assign o_push        = accept && row_ok && (ev != '0);
    assign o_row_ev.ev   = ev;
    assign o_row_ev.kind = kind;
    assign o_row_ev.base = base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_enable   <= ENABLE_RST;
            for (int r = 0; r < ROWS; r++) begin
                r_down[r] <= '0;
                for (int c = 0; c < COLS; c++) begin
                    r_last[r][c] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_DEBOUNCE: r_debounce <= i_cfg_data[DEB_W-1:0];
                    REG_ENABLE:   r_enable   <= i_cfg_data[EN_W-1:0];
                    default:      ;
                endcase
            end
            if (accept && row_ok) begin
                r_down[i_scan_row] <= n_down_row;
                for (int c = 0; c < COLS; c++) begin
                    r_last[i_scan_row][c] <= n_last_row[c];
                end
            end
        end
    end

endmodule

FILE: rtl/kmd_queue.sv
// Short queue of per-row event sets between front and back end.
module kmd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  kmd_pkg::t_row_ev   i_data,
    input  logic               i_pop,
    output kmd_pkg::t_row_ev   o_head,
    output kmd_pkg::t_q_status o_status
);
    import kmd_pkg::*;

    t_row_ev           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rptr];
    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/kmd_back.sv
// Back end: one event per cycle unless stalled, lowest column first per row set.
module kmd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kmd_pkg::t_row_ev          i_head,
    input  kmd_pkg::t_q_status        i_q_status,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [kmd_pkg::KEY_W-1:0] o_key_index,
    output logic                      o_event_kind,
    output logic                      o_last_event
);
    import kmd_pkg::*;

    logic [COLS-1:0]  r_mask, n_mask;
    logic [COLS-1:0]  r_kind, n_kind;
    logic [KEY_W-1:0] r_base, n_base;
    logic             r_out_valid, n_out_valid;
    logic [KEY_W-1:0] r_out_key, n_out_key;
    logic             r_out_kind, n_out_kind;
    logic             r_out_last, n_out_last;

    logic             adv;
    logic [COL_W-1:0] sel;
    logic [COLS-1:0]  mask_after;

    always_comb begin
        sel = '0;
        for (int c = COLS - 1; c >= 0; c--) begin
            if (r_mask[c]) begin
                sel = COL_W'(c);
            end
        end
    end

    always_comb begin
        adv         = (r_mask != '0) && (!r_out_valid || i_ready);
        mask_after  = adv ? (r_mask & ~(COLS'(1) << sel)) : r_mask;
        o_pop       = (mask_after == '0) && !i_q_status.empty;
        n_mask      = o_pop ? i_head.ev   : mask_after;
        n_kind      = o_pop ? i_head.kind : r_kind;
        n_base      = o_pop ? i_head.base : r_base;
        n_out_valid = r_out_valid;
        n_out_key   = r_out_key;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        if (adv) begin
            n_out_valid = 1'b1;
            n_out_key   = r_base + KEY_W'(sel);
            n_out_kind  = r_kind[sel];
            n_out_last  = (mask_after == '0);
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_base     <= n_base;
        r_out_key  <= n_out_key;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_key_index  = r_out_key;
    assign o_event_kind = r_out_kind;
    assign o_last_event = r_out_last;

endmodule

FILE: rtl/key_matrix_debounce_ghost_reject_top.sv
// Top level of the key matrix scanner with per-key debounce and ghost rejection.
//
// Each request on the input channel is one row scan sample (row, pressed-column
// mask, millisecond time). The front end classifies all columns of the row in
// the cycle the request is taken and updates the key state at once, so a new
// sample can be taken every cycle while the queue has room. Event sets go into
// a two-entry queue; the back end emits one event per cycle while the receiver is
// ready, lowest column first, through a registered output stage. A sample causes
// at most five events; a sample with no events is not queued and gives no output.
// Sustained rate is set by the back end's one-event-per-cycle serialiser. The
// first event of a sample passes the queue entry, the back end's column mask
// register and the output register before it shows on the outputs. No clearing
// pass follows reset: all key state is in flip-flops.
// Configuration: index 0 debounce time in ms (16 bit), index 1 key enable mask
// (20 bit); unknown indexes are ignored. Write only while the block is idle.
module key_matrix_debounce_ghost_reject_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [kmd_pkg::ROW_W-1:0]     i_scan_row,
    input  logic [kmd_pkg::COLS-1:0]      i_col_pressed,
    input  logic [kmd_pkg::TIME_W-1:0]    i_time_ms,
    // event channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [kmd_pkg::KEY_W-1:0]     o_key_index,
    output logic                          o_event_kind,
    output logic                          o_last_event,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [kmd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kmd_pkg::*;

    logic      push;
    logic      pop;
    t_row_ev   front_ev;
    t_row_ev   head;
    t_q_status q_status;

    // key state, debounce and ghost checks
    kmd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_scan_row    (i_scan_row),
        .i_col_pressed (i_col_pressed),
        .i_time_ms     (i_time_ms),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_row_ev      (front_ev)
    );

    // decouples classification from event delivery
    kmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_ev),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // one event per cycle onto the output register unless stalled
    kmd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_key_index  (o_key_index),
        .o_event_kind (o_event_kind),
        .o_last_event (o_last_event)
    );

endmodule

FILE: rtl/kmd_checker.sv
// Port-level checks of the key matrix block, bound to the top level.
module kmd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [kmd_pkg::KEY_W-1:0]     o_key_index,
    input logic                          o_event_kind,
    input logic                          o_last_event
);
    import kmd_pkg::*;

    // stalled event holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_key_index)
        && $stable(o_event_kind) && $stable(o_last_event))
        else $error("stalled event changed");

    // key index stays inside the matrix
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_key_index < KEY_W'(NKEYS)))
        else $error("key index out of range");

    // rest of a sample's events follow without a gap
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_event |=> o_valid)
        else $error("gap inside a sample's events");

    // events of one sample come in ascending key order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_event |=> o_key_index > $past(o_key_index))
        else $error("events out of column order");

    // output channel empty after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("event shown after reset");

endmodule

bind key_matrix_debounce_ghost_reject_top kmd_checker u_kmd_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the key matrix scanner with debounce and ghost rejection.
module testbench;
    import kmd_pkg::*;

    // Register indexes that the block does not decode; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    // Margin for an eventless sample to clear after the last predicted event.
    localparam int SETTLE_CYCLES   = 10;
    // Cycles with no request moved on either channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int ITEMS_PER_PHASE = 90;

    // One key event as it leaves the block.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             kind;
        logic             last;
    } t_key_event;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [ROW_W-1:0]      i_scan_row;
    logic [COLS-1:0]       i_col_pressed;
    logic [TIME_W-1:0]     i_time_ms;
    logic                  o_valid;
    logic                  i_ready;
    logic [KEY_W-1:0]      o_key_index;
    logic                  o_event_kind;
    logic                  o_last_event;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predicted key state and register copy.
    logic [DEB_W-1:0]      model_debounce;
    logic [EN_W-1:0]       model_enable;
    logic [NKEYS-1:0]      model_down;
    logic [TIME_W-1:0]     model_press_time [NKEYS];

    // Events predicted but not yet seen on the output, oldest first.
    t_key_event            pending_events [$];
    t_key_event            oldest_event;

    logic [TIME_W-1:0]     scan_time;
    int                    sender_idle_pct;
    int                    receiver_stall_pct;
    int                    error_count;
    int                    scans_sent;
    int                    events_checked;
    int                    quiet_cycles;

    key_matrix_debounce_ghost_reject_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_scan_row    (i_scan_row),
        .i_col_pressed (i_col_pressed),
        .i_time_ms     (i_time_ms),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_key_index   (o_key_index),
        .o_event_kind  (o_event_kind),
        .o_last_event  (o_last_event),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Key state predictor
    // ---------------------------------------------------------------------

    function automatic void reset_key_model();
        model_debounce = DEBOUNCE_RST;
        model_enable   = ENABLE_RST;
        model_down     = '0;
        for (int k = 0; k < NKEYS; k++) begin
            model_press_time[k] = '0;
        end
    endfunction

    // Walk the columns of one row sample, lowest first, and queue the key events
    // it causes. Only the final event of the sample carries the last flag.
    function automatic void predict_row_events(input logic [ROW_W-1:0]  row,
                                               input logic [COLS-1:0]   cols,
                                               input logic [TIME_W-1:0] now);
        t_key_event        found [COLS];
        int                n_found;
        int                idx;
        int                c;
        logic [COLS-1:0]   other_cols;
        logic [TIME_W-1:0] elapsed;
        n_found = 0;
        if (int'(row) < ROWS) begin
            for (c = 0; c < COLS; c++) begin
                idx = int'(row) * COLS + c;
                // keys past the enable mask count as disabled
                if (idx < EN_W && model_enable[idx]) begin
                    if (cols[c]) begin
                        other_cols    = cols;
                        other_cols[c] = 1'b0;
                        // elapsed time wraps with the millisecond counter
                        elapsed = now - model_press_time[idx];
                        if (!model_down[idx] && elapsed > TIME_W'(model_debounce)
                                && other_cols == '0) begin
                            model_down[idx]       = 1'b1;
                            model_press_time[idx] = now;
                            found[n_found]        = '{KEY_W'(idx), EV_PRESS, 1'b0};
                            n_found++;
                        end
                    end else if (model_down[idx]) begin
                        model_down[idx] = 1'b0;
                        found[n_found]  = '{KEY_W'(idx), EV_RELEASE, 1'b0};
                        n_found++;
                    end
                end
            end
        end
        for (c = 0; c < n_found; c++) begin
            if (c == n_found - 1) begin
                found[c].last = 1'b1;
            end
            pending_events.push_back(found[c]);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Sample channel: one request per call, random idle cycles ahead of it
    // ---------------------------------------------------------------------

    task automatic send_scan(input logic [ROW_W-1:0]  row,
                             input logic [COLS-1:0]   cols,
                             input logic [TIME_W-1:0] now);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_scan_row    = row;
        i_col_pressed = cols;
        i_time_ms     = now;
        do @(posedge i_clk); while (!o_ready);
        predict_row_events(row, cols, now);
        scans_sent++;
    endtask

    // Drop valid, wait for every predicted event, then let any eventless sample
    // still in the pipeline clear before the block is treated as idle.
    task automatic wait_until_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write; the predictor copy is updated the same way the block is.
    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        case (idx)
            REG_DEBOUNCE: begin
                model_debounce = data[DEB_W-1:0];
            end
            REG_ENABLE: begin
                model_enable = data[EN_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Event channel: random back-pressure and checking
    // ---------------------------------------------------------------------

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready = ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event: key_index %0d event_kind %0d last_event %0d",
                       o_key_index, o_event_kind, o_last_event);
                error_count++;
            end else begin
                oldest_event = pending_events.pop_front();
                events_checked++;
                if (o_key_index !== oldest_event.key) begin
                    $error("key_index: expected %0d, got %0d", oldest_event.key, o_key_index);
                    error_count++;
                end
                if (o_event_kind !== oldest_event.kind) begin
                    $error("event_kind: expected %0d, got %0d",
                           oldest_event.kind, o_event_kind);
                    error_count++;
                end
                if (o_last_event !== oldest_event.last) begin
                    $error("last_event: expected %0d, got %0d",
                           oldest_event.last, o_last_event);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any request moving on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no request moved for %0d cycles, %0d events outstanding",
                     quiet_cycles, pending_events.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset values: keys 0, 5 and 10 off, 100 ms debounce against a press time of zero.
    task automatic test_reset_defaults();
        send_scan(2'd0, 5'b00001, 1000);   // key 0 disabled
        send_scan(2'd0, 5'b00010, 100);    // exactly the debounce time: rejected
        send_scan(2'd0, 5'b00010, 101);    // press key 1
        send_scan(2'd0, 5'b00000, 150);    // release key 1
        send_scan(2'd2, 5'b00001, 200);    // key 10 disabled
    endtask

    // Several columns of a row pressed together must not produce a press.
    task automatic test_ghost_rejection();
        send_scan(2'd3, 5'b11111, 2000);   // whole row: nothing
        send_scan(2'd3, 5'b00010, 2001);   // press key 16
        send_scan(2'd3, 5'b00011, 2500);   // key 15 ghosted, key 16 held
        send_scan(2'd3, 5'b00001, 2600);   // release 16 and press 15 in one sample
        send_scan(2'd3, 5'b00000, 2700);   // release 15
    endtask

    // Press exactly at the debounce time is refused, one millisecond later accepted.
    task automatic test_debounce_edge();
        wait_until_idle();
        write_reg(REG_DEBOUNCE, CFG_DATA_W'(200));
        send_scan(2'd3, 5'b10000, 5000);
        send_scan(2'd3, 5'b00000, 5100);
        send_scan(2'd3, 5'b10000, 5200);
        send_scan(2'd3, 5'b10000, 5201);
        send_scan(2'd3, 5'b00000, 5300);
    endtask

    // Elapsed time measured across the wrap of the millisecond counter.
    task automatic test_time_wrap();
        wait_until_idle();
        write_reg(REG_DEBOUNCE, CFG_DATA_W'(100));
        send_scan(2'd1, 5'b00100, 32'hFFFF_FFF0);
        send_scan(2'd1, 5'b00000, 32'hFFFF_FFF8);
        send_scan(2'd1, 5'b00100, 32'h0000_0050);  // 96 ms after the press: refused
        send_scan(2'd1, 5'b00100, 32'h0000_0060);  // 112 ms: accepted
    endtask

    // Keys disabled while down keep their flag; re-enabling and releasing the
    // whole row then gives five releases from one sample.
    task automatic test_disabled_key_held();
        logic [CFG_DATA_W-1:0] mask;
        int c;
        wait_until_idle();
        write_reg(REG_DEBOUNCE, '0);
        write_reg(REG_ENABLE, '1);
        mask      = '1;
        scan_time = 32'h0001_0000;
        for (c = 0; c < COLS; c++) begin
            scan_time = scan_time + 10;
            send_scan(2'd2, COLS'(1) << c, scan_time);
            wait_until_idle();
            mask[2 * COLS + c] = 1'b0;
            write_reg(REG_ENABLE, mask);
        end
        write_reg(REG_ENABLE, '1);
        send_scan(2'd2, '0, scan_time + 1);
    endtask

    // Writes to undecoded indexes are ignored; an all-zero mask silences every key.
    task automatic test_register_writes();
        wait_until_idle();
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, '1);
        write_reg(REG_ENABLE, '0);
        send_scan(2'd0, 5'b00100, scan_time + 1000);
        send_scan(2'd1, 5'b00000, scan_time + 2000);
    endtask

    // One phase of random row samples. Most are a single pressed column or an
    // empty row, so keys really go down and up; the rest are random masks.
    task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct);
        logic [ROW_W-1:0] row;
        logic [COLS-1:0]  cols;
        int unsigned      pick;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                scan_time = $urandom();
            end else begin
                scan_time = scan_time + $urandom_range(0, 2 * int'(model_debounce) + 2);
            end
            row  = ROW_W'($urandom_range(0, ROWS - 1));
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                cols = COLS'(1) << $urandom_range(0, COLS - 1);
            end else if (pick < 80) begin
                cols = '0;
            end else begin
                cols = COLS'($urandom());
            end
            send_scan(row, cols, scan_time);
        end
    endtask

    // Four traffic patterns, each under its own register setting.
    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] deb_word;
        wait_until_idle();
        write_reg(REG_DEBOUNCE, '0);
        write_reg(REG_ENABLE, '1);
        run_random_phase(ITEMS_PER_PHASE, 0, 0);

        wait_until_idle();
        write_reg(REG_DEBOUNCE, '1);      // 65535 ms, upper data bits set too
        write_reg(REG_ENABLE, CFG_DATA_W'($urandom()));
        run_random_phase(ITEMS_PER_PHASE, 80, 0);

        wait_until_idle();
        deb_word             = CFG_DATA_W'($urandom());
        deb_word[DEB_W-1:0]  = DEB_W'($urandom_range(0, 400));
        write_reg(REG_DEBOUNCE, deb_word);
        write_reg(REG_ENABLE, '1);
        run_random_phase(ITEMS_PER_PHASE, 0, 80);

        wait_until_idle();
        write_reg(REG_DEBOUNCE, CFG_DATA_W'(DEBOUNCE_RST));
        write_reg(REG_ENABLE, CFG_DATA_W'(ENABLE_RST));
        run_random_phase(ITEMS_PER_PHASE, 12, 12);
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_scan_row         = '0;
        i_col_pressed      = '0;
        i_time_ms          = '0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        error_count        = 0;
        scans_sent         = 0;
        events_checked     = 0;
        quiet_cycles       = 0;
        scan_time          = '0;
        reset_key_model();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_ghost_rejection();
        test_debounce_edge();
        test_time_wrap();
        test_disabled_key_held();
        test_register_writes();
        test_random_traffic();

        wait_until_idle();
        $display("Sent %0d row samples and checked %0d key events", scans_sent, events_checked);
        $display("Covered debounce 0 to 65535, full/partial/empty masks and four idle patterns");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
